@@ rtl/signed_radix_digit_emitter_assert.svh @@
// Assertion macros for the signed radix digit emitter.
// Included by the top level; depends on nothing else.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_ASSERT_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRDE_ASSERT_HOLD(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/srde_pkg.sv @@
// Shared types, constants and the digit-to-ASCII function of the emitter.
// No dependencies.
package srde_pkg;

  localparam int MAG_W   = 64;
  localparam int NIB_W   = 4;
  localparam int DIGITS  = 20;
  localparam int DIG_W   = DIGITS * NIB_W;
  localparam int ND_W    = 5;
  localparam int CHAR_W  = 7;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LHEX = 2'd1;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              upper;
    logic [ND_W-1:0]   nd;
    logic [DIG_W-1:0]  digits;
  } srde_res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] nib,
                                                   input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-NIB_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + ext;
    end else if (upper) begin
      digit_char = CH_UA + ext - 7'd10;
    end else begin
      digit_char = CH_LA + ext - 7'd10;
    end
  endfunction

endpackage

@@ rtl/srde_if.sv @@
// Valid/ready channel interfaces for input words and character words.
// Depends on srde_pkg.
interface srde_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [srde_pkg::MAG_W-1:0] value;
  logic [srde_pkg::MODE_W-1:0]       mode;
  modport source (output valid, value, mode, input ready);
  modport sink   (input valid, value, mode, output ready);
endinterface

interface srde_out_if;
  logic                         valid;
  logic                         ready;
  logic [srde_pkg::CHAR_W-1:0]  character;
  logic [srde_pkg::ND_W-1:0]    char_count;
  logic                         last;
  modport source (output valid, character, char_count, last, input ready);
  modport sink   (input valid, character, char_count, last, output ready);
endinterface

@@ rtl/srde_conv.sv @@
// Conversion sequencer: shift-and-add-3 over 64 steps for decimal, direct
// nibble load for hex, then leading-zero trim one digit per cycle. Uses srde_pkg.
module srde_conv (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [srde_pkg::MAG_W-1:0] value,
  input  logic [srde_pkg::MODE_W-1:0]       mode,
  output logic                              idle,
  output srde_pkg::srde_res_t               res
);

  localparam int STEP_W = $clog2(srde_pkg::MAG_W);
  localparam int NIB    = srde_pkg::NIB_W;
  localparam int DW     = srde_pkg::DIG_W;

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_TRIM, S_DONE} state_t;

  state_t                          state_r;
  logic [srde_pkg::MAG_W-1:0]      bin_r;
  logic [DW-1:0]                   bcd_r;
  logic [STEP_W-1:0]               step_r;
  logic [srde_pkg::ND_W-1:0]       nd_r;
  logic                            neg_r;
  logic                            upper_r;
  srde_pkg::srde_res_t             res_r;

  logic [srde_pkg::MAG_W-1:0]      mag;
  logic [DW-1:0]                   bcd_adj;

  assign mag = value[srde_pkg::MAG_W-1] ? (~value + 64'd1) : value;

  // add 3 to every digit of 5 or more before each shift
  always_comb begin
    for (int i = 0; i < srde_pkg::DIGITS; i++) begin
      bcd_adj[i*NIB +: NIB] = (bcd_r[i*NIB +: NIB] >= 4'd5) ?
                              bcd_r[i*NIB +: NIB] + 4'd3 : bcd_r[i*NIB +: NIB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            neg_r   <= value[srde_pkg::MAG_W-1];
            upper_r <= (mode != srde_pkg::MODE_LHEX);
            nd_r    <= srde_pkg::ND_W'(srde_pkg::DIGITS);
            step_r  <= '0;
            if (mode == srde_pkg::MODE_DEC) begin
              bcd_r   <= '0;
              bin_r   <= mag;
              state_r <= S_SHIFT;
            end else begin
              bcd_r   <= {{(DW-srde_pkg::MAG_W){1'b0}}, mag};
              state_r <= S_TRIM;
            end
          end
        end
        S_SHIFT: begin
          bcd_r  <= {bcd_adj[DW-2:0], bin_r[srde_pkg::MAG_W-1]};
          bin_r  <= {bin_r[srde_pkg::MAG_W-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(srde_pkg::MAG_W - 1)) begin
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (nd_r > 5'd1 && bcd_r[DW-1 -: NIB] == '0) begin
            bcd_r <= {bcd_r[DW-NIB-1:0], {NIB{1'b0}}};
            nd_r  <= nd_r - 1'b1;
          end else begin
            res_r.valid  <= 1'b1;
            res_r.neg    <= neg_r;
            res_r.upper  <= upper_r;
            res_r.nd     <= nd_r;
            res_r.digits <= bcd_r;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle = (state_r == S_IDLE);
  assign res  = res_r;

endmodule

@@ rtl/srde_emit.sv @@
// Character emitter: sign then digits, most significant first, through a
// registered output word with count and last flag. Uses srde_pkg, srde_out_if.
module srde_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srde_pkg::srde_res_t  res,
  output logic                 busy,
  srde_out_if.source           out_chan
);

  localparam int NIB = srde_pkg::NIB_W;
  localparam int DW  = srde_pkg::DIG_W;

  logic                          sign_r;
  logic                          upper_r;
  logic [srde_pkg::ND_W-1:0]     rem_r;
  logic [DW-1:0]                 dig_r;
  logic                          out_valid_r;
  logic [srde_pkg::CHAR_W-1:0]   out_char_r;
  logic [srde_pkg::ND_W-1:0]     out_cnt_r;
  logic                          out_last_r;

  logic                          have_more;
  logic                          take;
  logic [srde_pkg::CHAR_W-1:0]   char_nxt;
  logic                          last_nxt;

  always_comb begin
    have_more = sign_r || (rem_r != '0);
    take      = have_more && (!out_valid_r || out_chan.ready);
    if (sign_r) begin
      char_nxt = srde_pkg::CH_MINUS;
      last_nxt = (rem_r == '0);
    end else begin
      char_nxt = srde_pkg::digit_char(dig_r[DW-1 -: NIB], upper_r);
      last_nxt = (rem_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      sign_r    <= res.neg;
      upper_r   <= res.upper;
      rem_r     <= res.nd;
      dig_r     <= res.digits;
      out_cnt_r <= '0;
    end else if (take) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        dig_r <= {dig_r[DW-NIB-1:0], {NIB{1'b0}}};
        rem_r <= rem_r - 1'b1;
      end
      out_char_r  <= char_nxt;
      out_cnt_r   <= out_cnt_r + 1'b1;
      out_last_r  <= last_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign busy                = out_valid_r || have_more;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.character  = out_char_r;
  assign out_chan.char_count = out_cnt_r;
  assign out_chan.last       = out_last_r;

endmodule

@@ rtl/signed_radix_digit_emitter.sv @@
// Signed 64-bit to decimal / hex ASCII text, one character word per cycle while the sink
// is ready; the 64-step shift loop (decimal only) and the leading-zero trim come first.
// Flow: one item at a time; a new input word is taken only when the sequencer is idle and
//   every character word of the previous item has gone out.
// Reset: synchronous active-low rst_n clears sequencer state and output valid.
// Depends on srde_pkg, srde_if, srde_conv, srde_emit and the assertion header.
`include "signed_radix_digit_emitter_assert.svh"

module signed_radix_digit_emitter (
  input  logic        clk,
  input  logic        rst_n,
  srde_in_if.sink     in_chan,
  srde_out_if.source  out_chan
);

  logic                 conv_idle;
  logic                 emit_busy;
  logic                 in_take;
  srde_pkg::srde_res_t  res;

  assign in_chan.ready = conv_idle && !emit_busy;
  assign in_take       = in_chan.valid && in_chan.ready;

  srde_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .value (in_chan.value),
    .mode  (in_chan.mode),
    .idle  (conv_idle),
    .res   (res)
  );

  srde_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .busy     (emit_busy),
    .out_chan (out_chan)
  );

  `SRDE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, !in_chan.ready, "ready after take")
  `SRDE_ASSERT_HOLD(a_no_take_while_out, clk, rst_n, out_chan.valid, !in_chan.ready, "ready with output pending")
  `SRDE_ASSERT_NEXT(a_last_ends, clk, rst_n, out_chan.valid && out_chan.ready && out_chan.last, !out_chan.valid, "word after last")
  `SRDE_ASSERT_NEXT(a_no_gap, clk, rst_n, out_chan.valid && out_chan.ready && !out_chan.last, out_chan.valid, "gap inside number")

endmodule

@@ tb/srde_text_checker.sv @@
`timescale 1ns / 100ps
// Checker for the signed radix digit emitter: predicts the character words of every
// accepted input word and compares them with the output channel. Depends on srde_pkg.
module srde_text_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [srde_pkg::MAG_W-1:0]       in_value,
  input  logic [srde_pkg::MODE_W-1:0]      in_mode,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [srde_pkg::CHAR_W-1:0]      out_character,
  input  logic [srde_pkg::ND_W-1:0]        out_char_count,
  input  logic                             out_last,
  output int                               pending_chars,
  output int                               fail_count
);

  typedef struct packed {
    logic [srde_pkg::CHAR_W-1:0] character;
    logic [srde_pkg::ND_W-1:0]   char_count;
    logic                        last;
  } text_char_t;

  text_char_t text_q[$];
  text_char_t want;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Sign first, then magnitude digits most significant first; mode 3 falls to uppercase.
  task automatic predict_text(input logic [srde_pkg::MAG_W-1:0] raw,
                              input logic [srde_pkg::MODE_W-1:0] mode);
    logic                        neg;
    logic [srde_pkg::MAG_W-1:0]  mag;
    logic [3:0]                  nib;
    logic [srde_pkg::CHAR_W-1:0] glyphs[$];
    string                       digit_set;
    byte                         glyph;
    int                          total;
    text_char_t                  ch;
    neg = raw[srde_pkg::MAG_W-1];
    mag = neg ? (~raw + 64'd1) : raw;
    digit_set = (mode == srde_pkg::MODE_LHEX) ? "0123456789abcdef" : "0123456789ABCDEF";
    do begin
      if (mode == srde_pkg::MODE_DEC) begin
        nib = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end else begin
        nib = mag[3:0];
        mag = mag >> 4;
      end
      glyph = digit_set[nib];
      glyphs.push_front(glyph[srde_pkg::CHAR_W-1:0]);
    end while (mag != 0);
    if (neg) glyphs.push_front(srde_pkg::CH_MINUS);
    total = glyphs.size();
    foreach (glyphs[i]) begin
      ch.character  = glyphs[i];
      ch.char_count = srde_pkg::ND_W'(i + 1);
      ch.last       = (i == total - 1);
      text_q.push_back(ch);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_text(in_value, in_mode);
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word char 0x%h count %0d last %0b",
                                    out_character, out_char_count, out_last));
        end else begin
          want = text_q.pop_front();
          if (out_character !== want.character)
            report_mismatch($sformatf("character 0x%h, want 0x%h",
                                      out_character, want.character));
          if (out_char_count !== want.char_count)
            report_mismatch($sformatf("char_count %0d, want %0d",
                                      out_char_count, want.char_count));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b at count %0d",
                                      out_last, want.last, want.char_count));
        end
      end
    end
    pending_chars <= text_q.size();
  end

endmodule

@@ tb/signed_radix_digit_emitter_test.sv @@
`timescale 1ns / 100ps
// Top of the signed radix digit emitter testbench: clock, reset, input words and
// output stalls, verdict. Depends on srde_pkg, srde_if, the block and srde_text_checker.
module signed_radix_digit_emitter_test;

  localparam logic [srde_pkg::MODE_W-1:0] MODE_UHEX = 2'd2;
  localparam logic [srde_pkg::MODE_W-1:0] MODE_ODD  = 2'd3;
  localparam logic [srde_pkg::MAG_W-1:0]  MOST_NEG  = 64'h8000_0000_0000_0000;
  localparam logic [srde_pkg::MAG_W-1:0]  MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_WORDS = 420;
  localparam int CALM_FIRST   = 150;
  localparam int CALM_LAST    = 230;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   cycles = 0;
  int   pending_chars;
  int   fail_count;

  srde_in_if  in_chan();
  srde_out_if out_chan();

  signed_radix_digit_emitter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  srde_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_value       (in_chan.value),
    .in_mode        (in_chan.mode),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_character  (out_chan.character),
    .out_char_count (out_chan.char_count),
    .out_last       (out_chan.last),
    .pending_chars  (pending_chars),
    .fail_count     (fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[signed_radix_digit_emitter] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // valid stays high between back-to-back words; it drops only in an idle gap
  task automatic send_word(input logic [srde_pkg::MAG_W-1:0] v,
                           input logic [srde_pkg::MODE_W-1:0] m);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    in_chan.mode  <= m;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic wait_drained();
    while (pending_chars != 0) @(posedge clk);
  endtask

  function automatic logic [srde_pkg::MAG_W-1:0] random_value();
    logic [srde_pkg::MAG_W-1:0] v;
    int                         k;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 1000));
      default: begin
        v = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) v = v * 64'd10;
        if ($urandom_range(0, 1)) v = v - 64'd1;
      end
    endcase
    if ($urandom_range(0, 1)) v = ~v + 64'd1;
    return v;
  endfunction

  initial begin
    rst_n          = 1'b0;
    calm           = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    in_chan.mode   = srde_pkg::MODE_DEC;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero in every mode, unit values, digit rollovers, both extremes, undefined mode
    send_word(64'd0, srde_pkg::MODE_DEC);
    send_word(64'd0, srde_pkg::MODE_LHEX);
    send_word(64'd0, MODE_UHEX);
    send_word(64'd0, MODE_ODD);
    send_word(64'd1, srde_pkg::MODE_DEC);
    send_word(-64'sd1, srde_pkg::MODE_DEC);
    send_word(-64'sd1, srde_pkg::MODE_LHEX);
    send_word(64'd9, srde_pkg::MODE_DEC);
    send_word(64'd10, srde_pkg::MODE_DEC);
    send_word(64'd15, srde_pkg::MODE_LHEX);
    send_word(64'd16, MODE_UHEX);
    send_word(64'hABCDEF, srde_pkg::MODE_LHEX);
    send_word(64'hABCDEF, MODE_UHEX);
    send_word(64'hABCDEF, MODE_ODD);
    send_word(64'h0123_4567_89AB_CDEF, srde_pkg::MODE_LHEX);
    send_word(MOST_POS, srde_pkg::MODE_DEC);
    send_word(MOST_POS, srde_pkg::MODE_LHEX);
    send_word(MOST_NEG, srde_pkg::MODE_DEC);
    send_word(MOST_NEG, srde_pkg::MODE_LHEX);
    send_word(MOST_NEG, MODE_UHEX);
    send_word(MOST_NEG, MODE_ODD);
    send_word(64'd999_999_999_999_999_999, srde_pkg::MODE_DEC);
    send_word(-64'sd1_000_000_000_000_000_000, srde_pkg::MODE_DEC);
    send_word(MOST_NEG + 64'd1, srde_pkg::MODE_DEC);

    // hold the input until the output side has emptied
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= CALM_FIRST) && (n < CALM_LAST);
      send_word(random_value(), srde_pkg::MODE_W'($urandom_range(0, 3)));
    end
    in_chan.valid <= 1'b0;
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[signed_radix_digit_emitter] OK");
    end else begin
      $display("[signed_radix_digit_emitter] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/srde_pkg.sv
rtl/srde_if.sv
rtl/srde_conv.sv
rtl/srde_emit.sv
rtl/signed_radix_digit_emitter.sv
tb/srde_text_checker.sv
tb/signed_radix_digit_emitter_test.sv
